// ===== hdl/iee_pkg.sv =====
package iee_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int OP_DEPTH    = 32;
    localparam int VAL_DEPTH   = 32;
    localparam int OP_AW       = $clog2(OP_DEPTH);
    localparam int VAL_AW      = $clog2(VAL_DEPTH);
    localparam int DIV_CW      = $clog2(VALUE_WIDTH);

    localparam logic [3:0] TK_DIGIT  = 4'd0;
    localparam logic [3:0] TK_PLUS   = 4'd1;
    localparam logic [3:0] TK_MINUS  = 4'd2;
    localparam logic [3:0] TK_TIMES  = 4'd3;
    localparam logic [3:0] TK_DIVIDE = 4'd4;
    localparam logic [3:0] TK_MIN    = 4'd5;
    localparam logic [3:0] TK_MAX    = 4'd6;
    localparam logic [3:0] TK_OPEN   = 4'd7;
    localparam logic [3:0] TK_CLOSE  = 4'd8;
    localparam logic [3:0] TK_COMMA  = 4'd9;
    localparam logic [3:0] TK_END    = 4'd10;

    localparam logic [2:0] OP_PLUS   = 3'd1;
    localparam logic [2:0] OP_MINUS  = 3'd2;
    localparam logic [2:0] OP_TIMES  = 3'd3;
    localparam logic [2:0] OP_DIVIDE = 3'd4;
    localparam logic [2:0] OP_MIN    = 3'd5;
    localparam logic [2:0] OP_MAX    = 3'd6;
    localparam logic [2:0] OP_OPEN   = 3'd7;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_DIV0  = 2'd1;
    localparam logic [1:0] ERR_STACK = 2'd2;
    localparam logic [1:0] ERR_PAREN = 2'd3;

    typedef struct packed {
        logic [3:0] operation;
        logic [3:0] digit;
    } t_in;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         error;
    } t_out;

    function automatic logic [1:0] rank_of(input logic [2:0] code);
        logic [1:0] r;
        r = 2'd0;
        if (code == OP_PLUS || code == OP_MINUS) begin
            r = 2'd1;
        end else if (code == OP_TIMES || code == OP_DIVIDE) begin
            r = 2'd2;
        end
        return r;
    endfunction

endpackage

// ===== hdl/infix_expression_evaluator_unit.sv =====
// Infix expression evaluator.
// Input channel: one token per beat (i_in_valid / o_in_stall, payload t_in).
// Output channel: one result beat per end token (o_out_valid / i_out_stall,
// payload t_out holding the value and the error code).
// A digit, min, max or open token is pushed from the idle state. Plus,
// minus, times and divide, close, comma and end walk the operator stack
// through one shared arithmetic unit: each operator inspected is read
// (S_OPRD) and checked (S_OPCHK), each operator applied passes S_APPLY,
// and a divide then runs S_DIV, one quotient bit a cycle. An end token
// emits its result from S_FIN. The operator and value stacks are memories
// with registered reads, hence the read step S_OPRD before each check.
// o_in_stall is high while a token is being worked on.
// The result sits in an output register; the next tokens are accepted while
// it waits. A second end token holds in its final step until the register
// is free.
// Reset empties both stacks, clears the error code and drops any pending
// result; stack contents need no clearing.
module infix_expression_evaluator_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  iee_pkg::t_in   i_in_data,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output iee_pkg::t_out  o_out_data,
    input  logic           i_out_stall
);
    import iee_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_OPRD  = 6'b000010,
        S_OPCHK = 6'b000100,
        S_APPLY = 6'b001000,
        S_DIV   = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    typedef enum logic [5:0] {
        M_BIN   = 6'b000001,
        M_CLOSE = 6'b000010,
        M_COMMA = 6'b000100,
        M_END   = 6'b001000,
        M_FN    = 6'b010000,
        M_DONE  = 6'b100000
    } t_mode;

    logic [2:0]             r_opmem [OP_DEPTH];
    logic [VALUE_WIDTH-1:0] r_valmem [VAL_DEPTH];

    t_state                 r_state, n_state;
    t_mode                  r_mode, n_mode;
    logic [OP_AW:0]         r_opc, n_opc;
    logic [VAL_AW:0]        r_vc, n_vc;
    logic [1:0]             r_err, n_err;
    logic [2:0]             r_tok, n_tok;
    logic [2:0]             r_aop, n_aop;
    logic [2:0]             r_optop;
    logic [VALUE_WIDTH-1:0] r_va, r_vb;
    logic [VALUE_WIDTH-1:0] r_quo, n_quo;
    logic [VALUE_WIDTH-1:0] r_dmb, n_dmb;
    logic [VALUE_WIDTH:0]   r_rem, n_rem;
    logic                   r_neg, n_neg;
    logic [DIV_CW-1:0]      r_dcnt, n_dcnt;
    logic                   r_out_valid, n_out_valid;
    t_out                   r_out, n_out;

    logic                   w_opwe, w_vwe;
    logic [OP_AW-1:0]       w_opwa;
    logic [2:0]             w_opwd;
    logic [VAL_AW-1:0]      w_vwa;
    logic [VALUE_WIDTH-1:0] w_vwd;
    logic [VAL_AW:0]        w_vc1, w_vc2;
    logic [OP_AW:0]         w_opc1;
    logic [VALUE_WIDTH:0]   w_rsh;
    logic [VALUE_WIDTH-1:0] w_qsh;
    logic [1:0]             w_raise;
    logic                   w_accept;

    assign w_vc1  = r_vc - 1'b1;
    assign w_vc2  = r_vc - 2'd2;
    assign w_opc1 = r_opc - 1'b1;
    assign w_accept = i_in_valid && (r_state == S_IDLE);
    assign w_rsh  = {r_rem[VALUE_WIDTH-1:0], r_quo[VALUE_WIDTH-1]};
    assign w_qsh  = {r_quo[VALUE_WIDTH-2:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (w_opwe) begin
            r_opmem[w_opwa] <= w_opwd;
        end
        if (w_vwe) begin
            r_valmem[w_vwa] <= w_vwd;
        end
        r_optop <= r_opmem[w_opc1[OP_AW-1:0]];
        r_vb    <= r_valmem[w_vc1[VAL_AW-1:0]];
        r_va    <= r_valmem[w_vc2[VAL_AW-1:0]];
    end

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_opc       = r_opc;
        n_vc        = r_vc;
        n_tok       = r_tok;
        n_aop       = r_aop;
        n_quo       = r_quo;
        n_dmb       = r_dmb;
        n_rem       = r_rem;
        n_neg       = r_neg;
        n_dcnt      = r_dcnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_raise     = ERR_NONE;
        w_opwe      = 1'b0;
        w_opwa      = r_opc[OP_AW-1:0];
        w_opwd      = r_tok;
        w_vwe       = 1'b0;
        w_vwa       = w_vc2[VAL_AW-1:0];
        w_vwd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_tok = i_in_data.operation[2:0];
                    if (i_in_data.operation == TK_DIGIT) begin
                        if (r_vc >= (VAL_AW+1)'(VAL_DEPTH)) begin
                            w_raise = ERR_STACK;
                        end else begin
                            w_vwe = 1'b1;
                            w_vwa = r_vc[VAL_AW-1:0];
                            w_vwd = VALUE_WIDTH'(i_in_data.digit);
                            n_vc  = r_vc + 1'b1;
                        end
                    end else if (i_in_data.operation == TK_MIN
                                 || i_in_data.operation == TK_MAX
                                 || i_in_data.operation == TK_OPEN) begin
                        if (r_opc >= (OP_AW+1)'(OP_DEPTH)) begin
                            w_raise = ERR_STACK;
                        end else begin
                            w_opwe = 1'b1;
                            w_opwd = i_in_data.operation[2:0];
                            n_opc  = r_opc + 1'b1;
                        end
                    end else if (i_in_data.operation >= TK_PLUS
                                 && i_in_data.operation <= TK_DIVIDE) begin
                        n_mode  = M_BIN;
                        n_state = S_OPRD;
                    end else if (i_in_data.operation == TK_CLOSE) begin
                        n_mode  = M_CLOSE;
                        n_state = S_OPRD;
                    end else if (i_in_data.operation == TK_COMMA) begin
                        n_mode  = M_COMMA;
                        n_state = S_OPRD;
                    end else if (i_in_data.operation == TK_END) begin
                        n_mode  = M_END;
                        n_state = S_OPRD;
                    end
                end
            end
            S_OPRD: begin
                n_state = S_OPCHK;
            end
            S_OPCHK: begin
                n_aop   = r_optop;
                n_state = S_IDLE;
                unique case (r_mode)
                    M_BIN: begin
                        if (r_opc == '0 || r_optop == OP_OPEN
                            || rank_of(r_optop) < rank_of(r_tok)) begin
                            if (r_opc >= (OP_AW+1)'(OP_DEPTH)) begin
                                w_raise = ERR_STACK;
                            end else begin
                                w_opwe = 1'b1;
                                n_opc  = r_opc + 1'b1;
                            end
                        end else begin
                            n_opc   = w_opc1;
                            n_state = S_APPLY;
                        end
                    end
                    M_CLOSE, M_COMMA: begin
                        if (r_opc == '0) begin
                            w_raise = ERR_PAREN;
                        end else if (r_optop == OP_OPEN) begin
                            if (r_mode == M_CLOSE) begin
                                n_opc   = w_opc1;
                                n_mode  = M_FN;
                                n_state = S_OPRD;
                            end
                        end else begin
                            n_opc   = w_opc1;
                            n_state = S_APPLY;
                        end
                    end
                    M_FN: begin
                        if (r_opc != '0 && (r_optop == OP_MIN || r_optop == OP_MAX)) begin
                            n_opc   = w_opc1;
                            n_mode  = M_DONE;
                            n_state = S_APPLY;
                        end
                    end
                    M_END: begin
                        if (r_opc == '0) begin
                            n_state = S_FIN;
                        end else begin
                            n_opc   = w_opc1;
                            n_state = S_APPLY;
                        end
                    end
                    M_DONE: begin
                        n_state = S_IDLE;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_APPLY: begin
                n_state = S_OPRD;
                if (r_aop == OP_OPEN) begin
                    w_raise = ERR_PAREN;
                end else if (r_vc < (VAL_AW+1)'(2)) begin
                    w_raise = ERR_STACK;
                end else if (r_aop == OP_DIVIDE) begin
                    if (r_vb == '0) begin
                        w_raise = ERR_DIV0;
                        w_vwe   = 1'b1;
                        w_vwd   = '0;
                        n_vc    = w_vc1;
                    end else begin
                        n_neg   = r_va[VALUE_WIDTH-1] ^ r_vb[VALUE_WIDTH-1];
                        n_quo   = r_va[VALUE_WIDTH-1] ? (~r_va + 1'b1) : r_va;
                        n_dmb   = r_vb[VALUE_WIDTH-1] ? (~r_vb + 1'b1) : r_vb;
                        n_rem   = '0;
                        n_dcnt  = DIV_CW'(VALUE_WIDTH - 1);
                        n_state = S_DIV;
                    end
                end else begin
                    w_vwe = 1'b1;
                    n_vc  = w_vc1;
                    unique case (r_aop)
                        OP_PLUS:  w_vwd = r_va + r_vb;
                        OP_MINUS: w_vwd = r_va - r_vb;
                        OP_TIMES: w_vwd = VALUE_WIDTH'(r_va * r_vb);
                        OP_MIN:   w_vwd = ($signed(r_vb) < $signed(r_va)) ? r_vb : r_va;
                        OP_MAX:   w_vwd = ($signed(r_va) < $signed(r_vb)) ? r_vb : r_va;
                        default:  w_vwd = '0;
                    endcase
                end
            end
            S_DIV: begin
                if (w_rsh >= {1'b0, r_dmb}) begin
                    n_rem = w_rsh - {1'b0, r_dmb};
                    n_quo = w_qsh | VALUE_WIDTH'(1);
                end else begin
                    n_rem = w_rsh;
                    n_quo = w_qsh;
                end
                n_dcnt = r_dcnt - 1'b1;
                if (r_dcnt == '0) begin
                    w_vwe   = 1'b1;
                    w_vwd   = r_neg ? (~n_quo + 1'b1) : n_quo;
                    n_vc    = w_vc1;
                    n_state = S_OPRD;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out.value = (r_vc == '0) ? '0 : 32'($signed(r_vb));
                    n_out.error = (r_err != ERR_NONE) ? r_err
                                : ((r_vc != (VAL_AW+1)'(1)) ? ERR_STACK : ERR_NONE);
                    n_opc   = '0;
                    n_vc    = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_err = r_err;
        if (r_state == S_FIN && n_state == S_IDLE) begin
            n_err = ERR_NONE;
        end else if (r_err == ERR_NONE) begin
            n_err = w_raise;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= M_DONE;
            r_opc       <= '0;
            r_vc        <= '0;
            r_err       <= ERR_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_opc       <= n_opc;
            r_vc        <= n_vc;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
        r_tok  <= n_tok;
        r_aop  <= n_aop;
        r_quo  <= n_quo;
        r_dmb  <= n_dmb;
        r_rem  <= n_rem;
        r_neg  <= n_neg;
        r_dcnt <= n_dcnt;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_vc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vc <= (VAL_AW+1)'(VAL_DEPTH))
        else $error("value count beyond depth");
    a_opc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_opc <= (OP_AW+1)'(OP_DEPTH))
        else $error("operator count beyond depth");
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dmb != '0))
        else $error("divider running on zero divisor");
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN))
        else $error("result raised outside final step");
    a_fin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && n_state == S_IDLE) |=> (r_vc == '0 && r_opc == '0))
        else $error("stacks not cleared after end");

endmodule
